// ===== design/hfa_pkg.sv =====
// Shared constants, types and the build-time coefficient table of the Hilbert FIR.
// The top level depends on this package; it depends on nothing.
`default_nettype none

package hfa_pkg;

	localparam int HALF_TAPS   = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 18;
	localparam int CH_BITS     = 3;

	localparam int NTAPS     = 2 * HALF_TAPS + 1;
	localparam int NODD      = (HALF_TAPS + 1) / 2;
	localparam int ADDR_BITS = $clog2(NTAPS);
	localparam int FILL_BITS = $clog2(NTAPS + 1);
	localparam int K_BITS    = $clog2(NODD);
	localparam int DIFF_BITS = SAMPLE_BITS + 1;
	localparam int PROD_BITS = COEF_BITS + DIFF_BITS;
	localparam int ACC_BITS  = PROD_BITS + K_BITS + 1;

	localparam longint Q30    = 64'sd1 << 30;
	localparam longint PI_Q30 = 64'sd3373259426;

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef coef_t coef_tab_t [NODD];

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} hfa_state_t;

	// Signed division truncating toward zero, done by shift and subtract.
	// Only used while the coefficient table is built.
	function automatic longint div_trunc(input longint n, input longint d);
		logic [63:0] un;
		logic [63:0] ud;
		logic [63:0] q;
		logic [64:0] r;
		logic        neg;
		neg = (n < 0) ^ (d < 0);
		un  = (n < 0) ? -n : n;
		ud  = (d < 0) ? -d : d;
		q   = '0;
		r   = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], un[i]};
			if (r >= {1'b0, ud}) begin
				r    = r - {1'b0, ud};
				q[i] = 1'b1;
			end
		end
		return neg ? -$signed(q) : $signed(q);
	endfunction

	// Taylor series of cos on [0, pi/4], Q30 in and out, truncating divisions.
	function automatic longint cos_q30(input longint a);
		longint a2;
		longint t;
		a2 = (a * a) >>> 30;
		t  = Q30;
		for (int k = 7; k >= 1; k--) begin
			t = Q30 - div_trunc((t * a2) >>> 30, longint'((2 * k - 1) * (2 * k)));
		end
		return t;
	endfunction

	function automatic longint sin_q30(input longint a);
		longint a2;
		longint t;
		a2 = (a * a) >>> 30;
		t  = Q30;
		for (int k = 7; k >= 1; k--) begin
			t = Q30 - div_trunc((t * a2) >>> 30, longint'((2 * k) * (2 * k + 1)));
		end
		return (t * a) >>> 30;
	endfunction

	// cos(pi*j/HALF_TAPS) in Q30, folded into the first octant.
	function automatic longint cos_pi_frac(input longint j);
		longint u;
		longint r;
		logic   neg;
		u   = j;
		neg = 1'b0;
		if (2 * u > HALF_TAPS) begin
			u   = HALF_TAPS - u;
			neg = 1'b1;
		end
		if (4 * u > HALF_TAPS) begin
			r = sin_q30((PI_Q30 * (HALF_TAPS - 2 * u)) / (2 * HALF_TAPS));
		end else begin
			r = cos_q30((PI_Q30 * u) / HALF_TAPS);
		end
		return neg ? -r : r;
	endfunction

	// Blackman window value at tap offset j, Q30, clamped at zero.
	function automatic longint blackman_q30(input longint j);
		longint c1;
		longint c2;
		longint w;
		c1 = cos_pi_frac(j);
		c2 = ((c1 * c1) >>> 29) - Q30;
		w  = 64'sd450971566 + c1 / 2 + (2 * c2) / 25;
		if (w < 0) begin
			w = 0;
		end
		return w;
	endfunction

	// Odd-tap coefficients, entry k belongs to tap offset 2k+1.
	// The gain at a quarter of the sample rate is normalized to one.
	function automatic coef_tab_t build_coefs();
		coef_tab_t tab;
		longint    s;
		longint    x;
		longint    c;
		longint    cmax;
		longint    jj;
		s    = 0;
		cmax = (64'sd1 <<< (COEF_BITS - 1)) - 1;
		for (int j = 1; j <= HALF_TAPS; j += 2) begin
			jj = longint'(j);
			x  = div_trunc(blackman_q30(jj), jj);
			s  = ((j & 3) == 1) ? s + x : s - x;
		end
		for (int k = 0; k < NODD; k++) begin
			jj = longint'(2 * k + 1);
			c  = 0;
			if (s > 0) begin
				c = div_trunc(div_trunc(blackman_q30(jj), jj) * (64'sd1 <<< (COEF_BITS - 1)) + s,
					2 * s);
				if (c > cmax) begin
					c = cmax;
				end
			end
			tab[k] = c[COEF_BITS-1:0];
		end
		return tab;
	endfunction

	localparam coef_tab_t COEF_TAB = build_coefs();

endpackage

`default_nettype wire

// ===== design/hfa_ram.sv =====
// Generic simple dual-port RAM: one write port and two registered read ports.
// Used for the sample delay line; no dependencies.
`default_nettype none

module hfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 513
) (
	input  wire  logic                     clk,
	input  wire  logic                     we,
	input  wire  logic [$clog2(DEPTH)-1:0] waddr,
	input  wire  logic [WIDTH-1:0]         wdata,
	input  wire  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic       [WIDTH-1:0]         rdata_a,
	input  wire  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic       [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== design/hilbert_fir_analytic_signal.sv =====
// Hilbert FIR analytic-signal generator for one channel of an interleaved stream.
// Depends on hfa_pkg and the delay-line RAM hfa_ram.
//
// Usage: requests arrive on in_valid/in_ready carrying sample, channel and is_pad.
// A request of another channel than channel_select is dropped in its accept cycle.
// A kept sample or a pad (which pushes zero) is written into a circular delay line
// of 2*HALF_TAPS+1 entries. Once HALF_TAPS pushes have gone before it, each push
// produces one result on out_valid/out_ready: real_part is the centre sample and
// imag_part the rounded, saturated antisymmetric FIR sum, so results lag the input
// by HALF_TAPS pushes; HALF_TAPS pads at the end of a signal flush the tail.
// A push that produces a result occupies the block for the centre fetch, then one
// multiply-accumulate unit visits one odd tap pair per cycle, the pair being
// fetched through the two read ports of the delay-line RAM, then the fetch and
// multiply registers drain and the rounding step follows. Dropped requests and
// filling pushes leave the block idle. The result register lets a new request in
// while the previous result waits; a stalled receiver holds the next result in
// the final step. Reset empties the delay line logically (a fill count masks
// never-written entries, no clearing pass), sets channel_select to zero and drops
// any result. channel_select is written through cfg_wr_en/cfg_wr_data; the user
// must do so only while the block is idle, which the block does not enforce.
`default_nettype none

module hilbert_fir_analytic_signal
	import hfa_pkg::*;
(
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          cfg_wr_en,
	input  wire  logic        [CH_BITS-1:0]     cfg_wr_data,
	input  wire  logic                          in_valid,
	output logic                                in_ready,
	input  wire  logic signed [SAMPLE_BITS-1:0] sample,
	input  wire  logic        [CH_BITS-1:0]     channel,
	input  wire  logic                          is_pad,
	output logic                                out_valid,
	input  wire  logic                          out_ready,
	output logic signed       [SAMPLE_BITS-1:0] real_part,
	output logic signed       [SAMPLE_BITS-1:0] imag_part
);

	localparam logic [ADDR_BITS:0]   NTAPS_W = (ADDR_BITS + 1)'(NTAPS);
	localparam logic [ADDR_BITS:0]   HALF_W  = (ADDR_BITS + 1)'(HALF_TAPS);
	localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(NTAPS);
	localparam logic [FILL_BITS-1:0] FILL_HALF = FILL_BITS'(HALF_TAPS);
	localparam logic [K_BITS-1:0]    K_LAST  = K_BITS'(NODD - 1);

	hfa_state_t state_q;
	hfa_state_t state_d;

	logic [CH_BITS-1:0]   chan_sel_q;
	logic [ADDR_BITS-1:0] wa_q;
	logic [FILL_BITS-1:0] fill_q;
	logic [ADDR_BITS-1:0] pa_q;
	logic [ADDR_BITS-1:0] pb_q;
	logic [K_BITS-1:0]    k_q;

	logic iss_s1;
	logic iss_s2;
	logic cen_s1;
	logic va_s1;
	logic vb_s1;
	coef_t coef_s1;
	logic signed [PROD_BITS-1:0]   prod_s2;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [SAMPLE_BITS-1:0] centre_q;

	logic out_valid_q;
	logic signed [SAMPLE_BITS-1:0] real_q;
	logic signed [SAMPLE_BITS-1:0] imag_q;

	logic push;
	logic load_out;
	logic ram_we;
	logic [ADDR_BITS-1:0] raddr_a;
	logic [ADDR_BITS-1:0] raddr_b;
	logic [SAMPLE_BITS-1:0] rdata_a;
	logic [SAMPLE_BITS-1:0] rdata_b;
	logic [SAMPLE_BITS-1:0] wdata;

	logic [ADDR_BITS:0] cen_sum;
	logic [ADDR_BITS:0] pa0_sum;
	logic [ADDR_BITS:0] pb0_sum;
	logic [ADDR_BITS:0] pa_sum;
	logic [ADDR_BITS:0] pb_sum;
	logic [ADDR_BITS-1:0] cen_addr;
	logic [ADDR_BITS-1:0] pa0;
	logic [ADDR_BITS-1:0] pb0;
	logic [ADDR_BITS-1:0] pa_next;
	logic [ADDR_BITS-1:0] pb_next;
	logic [ADDR_BITS-1:0] wa_next;
	logic va;
	logic vb;

	logic signed [SAMPLE_BITS-1:0] da;
	logic signed [SAMPLE_BITS-1:0] db;
	logic signed [DIFF_BITS-1:0]   diff;
	logic signed [ACC_BITS-1:0]    rnd;
	logic signed [ACC_BITS-1:0]    shifted;
	logic [ACC_BITS-SAMPLE_BITS:0] hi_bits;
	logic signed [SAMPLE_BITS-1:0] imag_sat;

	// ---------------------------------------------------------------
	// Address arithmetic on the circular delay line.
	// wa_q is the next write slot, so after a push the centre sits at wa_q+HALF_TAPS.
	// ---------------------------------------------------------------
	always_comb begin
		cen_sum = (ADDR_BITS + 1)'(wa_q) + HALF_W;
		pa0_sum = cen_sum + (ADDR_BITS + 1)'(1);
		pb0_sum = cen_sum - (ADDR_BITS + 1)'(1);
		cen_addr = (cen_sum >= NTAPS_W) ? ADDR_BITS'(cen_sum - NTAPS_W) : ADDR_BITS'(cen_sum);
		pa0 = (pa0_sum >= NTAPS_W) ? ADDR_BITS'(pa0_sum - NTAPS_W) : ADDR_BITS'(pa0_sum);
		pb0 = (pb0_sum >= NTAPS_W) ? ADDR_BITS'(pb0_sum - NTAPS_W) : ADDR_BITS'(pb0_sum);

		pa_sum  = (ADDR_BITS + 1)'(pa_q) + (ADDR_BITS + 1)'(2);
		pa_next = (pa_sum >= NTAPS_W) ? ADDR_BITS'(pa_sum - NTAPS_W) : ADDR_BITS'(pa_sum);
		pb_sum  = (pb_q < ADDR_BITS'(2)) ?
			(ADDR_BITS + 1)'(pb_q) + NTAPS_W - (ADDR_BITS + 1)'(2) :
			(ADDR_BITS + 1)'(pb_q) - (ADDR_BITS + 1)'(2);
		pb_next = ADDR_BITS'(pb_sum);

		wa_next = (wa_q == ADDR_BITS'(NTAPS - 1)) ? '0 : wa_q + ADDR_BITS'(1);

		// Slots are written in address order after reset, so a slot below the
		// fill count holds a sample and the rest still read as zero.
		va = (fill_q == FILL_FULL) ||
			((ADDR_BITS + 1)'(pa_q) < (ADDR_BITS + 1)'(fill_q));
		vb = (fill_q == FILL_FULL) ||
			((ADDR_BITS + 1)'(pb_q) < (ADDR_BITS + 1)'(fill_q));
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	assign push = in_valid && in_ready && (is_pad || (channel == chan_sel_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (push && (fill_q >= FILL_HALF)) begin
					state_d = ST_CENTER;
				end
			end
			ST_CENTER: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (k_q == K_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!iss_s1) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ram_we   = 1'b0;
		load_out = 1'b0;
		raddr_a  = pa_q;
		raddr_b  = pb_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ram_we   = push;
			end
			ST_CENTER: begin
				raddr_a = cen_addr;
			end
			ST_RUN: begin
				raddr_a = pa_q;
				raddr_b = pb_q;
			end
			ST_DRAIN: begin
				raddr_a = pa_q;
			end
			ST_FIN: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chan_sel_q  <= '0;
			wa_q        <= '0;
			fill_q      <= '0;
			iss_s1      <= 1'b0;
			iss_s2      <= 1'b0;
			cen_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				chan_sel_q <= cfg_wr_data;
			end
			if (ram_we) begin
				wa_q <= wa_next;
				if (fill_q != FILL_FULL) begin
					fill_q <= fill_q + FILL_BITS'(1);
				end
			end
			iss_s1 <= (state_q == ST_RUN);
			iss_s2 <= iss_s1;
			cen_s1 <= (state_q == ST_CENTER);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Delay line
	// ---------------------------------------------------------------
	assign wdata = is_pad ? '0 : sample;

	hfa_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(NTAPS)
	) u_delay (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (wa_q),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	// ---------------------------------------------------------------
	// Multiply-accumulate unit: fetch, multiply, accumulate.
	// Port A walks the newer side of the centre, port B the older side.
	// ---------------------------------------------------------------
	always_comb begin
		da   = va_s1 ? $signed(rdata_a) : '0;
		db   = vb_s1 ? $signed(rdata_b) : '0;
		diff = DIFF_BITS'(da) - DIFF_BITS'(db);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CENTER) begin
			pa_q  <= pa0;
			pb_q  <= pb0;
			k_q   <= '0;
			acc_q <= '0;
		end else begin
			if (state_q == ST_RUN) begin
				pa_q <= pa_next;
				pb_q <= pb_next;
				k_q  <= k_q + K_BITS'(1);
			end
			if (iss_s2) begin
				acc_q <= acc_q + ACC_BITS'(prod_s2);
			end
		end
		va_s1   <= va;
		vb_s1   <= vb;
		coef_s1 <= COEF_TAB[k_q];
		prod_s2 <= PROD_BITS'(coef_s1) * PROD_BITS'(diff);
		if (cen_s1) begin
			centre_q <= $signed(rdata_a);
		end
		if (load_out) begin
			real_q <= centre_q;
			imag_q <= imag_sat;
		end
	end

	// Round half up, then saturate when the bits above the sign do not agree.
	always_comb begin
		rnd     = acc_q + (ACC_BITS'(1) <<< (COEF_BITS - 2));
		shifted = rnd >>> (COEF_BITS - 1);
		hi_bits = shifted[ACC_BITS-1:SAMPLE_BITS-1];
		if ((&hi_bits) || !(|hi_bits)) begin
			imag_sat = shifted[SAMPLE_BITS-1:0];
		end else if (shifted[ACC_BITS-1]) begin
			imag_sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
		end else begin
			imag_sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
		end
	end

	assign out_valid = out_valid_q;
	assign real_part = real_q;
	assign imag_part = imag_q;

endmodule

`default_nettype wire
